// File: rtl/imuoi_pkg.sv
`timescale 1ns / 1ps

package imuoi_pkg;

    // port widths
    localparam int S_DATA_W = 152;
    localparam int M_DATA_W = 240;
    localparam int CFG_AW   = 4;
    localparam int CFG_DW   = 32;

    // shared multiply-accumulate unit
    localparam int MA_W   = 36;
    localparam int MB_W   = 24;
    localparam int PROD_W = 60;
    localparam int ACC_W  = 64;

    // rotation unit
    localparam int CORDIC_STEPS = 24;
    localparam int CX_W         = 34;
    localparam int CZ_W         = 33;
    localparam logic signed [CX_W-1:0] CORDIC_X0 = 34'sd652032874;

    // heading step gain, round(2^44 / (2 pi 10^6))
    localparam logic signed [MB_W-1:0] HEAD_K = 24'sd2799883;

    typedef enum logic [2:0] {
        DST_REL,
        DST_MNT,
        DST_N2,
        DST_TMP,
        DST_POSX,
        DST_POSY,
        DST_HEAD
    } mac_dst_t;

    // issue control for one product term
    typedef struct packed {
        logic     en;
        logic     clr;
        logic     neg;
        logic     last;
        mac_dst_t dst;
        logic [1:0] idx;
    } mac_ctl_t;

    // a finished sum waiting in the accumulator
    typedef struct packed {
        logic     valid;
        mac_dst_t dst;
        logic [1:0] idx;
    } mac_fin_t;

    // arctangent of 2^-i as a binary angle
    function automatic logic [29:0] atan_angle(input logic [4:0] i);
        logic [29:0] v;
        begin
            case (i)
                5'd0:    v = 30'd536870912;
                5'd1:    v = 30'd316933406;
                5'd2:    v = 30'd167458907;
                5'd3:    v = 30'd85004756;
                5'd4:    v = 30'd42667331;
                5'd5:    v = 30'd21354465;
                5'd6:    v = 30'd10679838;
                5'd7:    v = 30'd5340245;
                5'd8:    v = 30'd2670163;
                5'd9:    v = 30'd1335087;
                5'd10:   v = 30'd667544;
                5'd11:   v = 30'd333772;
                5'd12:   v = 30'd166886;
                5'd13:   v = 30'd83443;
                5'd14:   v = 30'd41722;
                5'd15:   v = 30'd20861;
                5'd16:   v = 30'd10430;
                5'd17:   v = 30'd5215;
                5'd18:   v = 30'd2608;
                5'd19:   v = 30'd1304;
                5'd20:   v = 30'd652;
                5'd21:   v = 30'd326;
                5'd22:   v = 30'd163;
                5'd23:   v = 30'd81;
                default: v = 30'd0;
            endcase
            return v;
        end
    endfunction

    // sign of term t in component g of a hamilton product
    function automatic logic ham_neg(input logic [1:0] g, input logic [1:0] t);
        logic n;
        begin
            case (g)
                2'd0:    n = (t != 2'd0);
                2'd1:    n = (t == 2'd3);
                2'd2:    n = (t == 2'd1);
                default: n = (t == 2'd2);
            endcase
            return n;
        end
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
        logic signed [15:0] r;
        begin
            if (v > 64'sd32767)
                r = 16'sh7fff;
            else if (v < -64'sd32768)
                r = 16'sh8000;
            else
                r = 16'(v);
            return r;
        end
    endfunction

endpackage

// File: rtl/imuoi_mac.sv
`timescale 1ns / 1ps

module imuoi_mac (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  imuoi_pkg::mac_ctl_t                   ctl,
    input  logic signed [imuoi_pkg::MA_W-1:0]     a,
    input  logic signed [imuoi_pkg::MB_W-1:0]     b,
    output imuoi_pkg::mac_fin_t                   fin,
    output logic signed [imuoi_pkg::ACC_W-1:0]    acc
);
    import imuoi_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    mac_ctl_t                 ctl_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    mac_fin_t                 fin_reg;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  base;

    assign prod_next = a * b;

    // accumulate, a cleared sum starts at its rounding offset, or at zero for the norm and temporary sums
    always_comb
    begin
        prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        term     = ctl_reg.neg ? -prod_ext : prod_ext;
        if (ctl_reg.clr)
        begin
            case (ctl_reg.dst)
                DST_REL, DST_MNT, DST_POSX, DST_POSY: base = 64'sd16384;
                DST_HEAD:                             base = 64'sd8388608;
                default:                              base = '0;
            endcase
        end
        else
        begin
            base = acc_reg;
        end
        acc_next = base + term;
    end

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
            fin_reg <= '0;
        end
        else
        begin
            ctl_reg       <= ctl;
            fin_reg.valid <= ctl_reg.en & ctl_reg.last;
            fin_reg.dst   <= ctl_reg.dst;
            fin_reg.idx   <= ctl_reg.idx;
        end
    end

    // product and sum
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (ctl_reg.en)
            acc_reg <= acc_next;
    end

    assign fin = fin_reg;
    assign acc = acc_reg;

endmodule

// File: rtl/imu_odometry_integrator.sv
`timescale 1ns / 1ps

// channel   | direction | payload
// s_*       | in        | tuser: command; tdata: vel, seq, quaternion, yaw rate, elapsed
// m_*       | out       | tdata: seq_out, pos_x, pos_y, rel quaternion, head quaternion
// apb       | in/out    | mount quaternion w, x, y, z at byte addresses 0, 4, 8, 12
//
// a velocity item is taken and gives no result
// an imu item spends most of its time in the bit-serial divider, which works the four
// head components in turn and skips the division when the norm is zero;
// one multiply-accumulate unit carries all products, the rest is sqrt, division and rotation
// s_tready is high only while idle; a finished result waits in the output register
// reset clears the reference, velocity, heading and position; TRIG_TABLE_DEPTH is a
// power of two

module imu_odometry_integrator #(
    parameter int POS_WIDTH        = 48,
    parameter int TRIG_TABLE_DEPTH = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // vel_x, vel_y, seq, quat_w, quat_x, quat_y, quat_z, ang_vel_z, elapsed
    input  logic [imuoi_pkg::S_DATA_W-1:0]     s_tdata,
    // command
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // seq_out, pos_x, pos_y, rel_w, rel_x, rel_y, rel_z, head_w, head_x, head_y, head_z
    output logic [imuoi_pkg::M_DATA_W-1:0]     m_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [imuoi_pkg::CFG_AW-1:0]       paddr,
    input  logic [imuoi_pkg::CFG_DW-1:0]       pwdata,
    output logic [imuoi_pkg::CFG_DW-1:0]       prdata,
    output logic                               pready
);
    import imuoi_pkg::*;

    localparam int TRIG_BITS = $clog2(TRIG_TABLE_DEPTH);
    localparam logic CMD_VEL = 1'b0;
    localparam logic [1:0] REG_MOUNT_W = 2'd0;
    localparam logic [1:0] REG_MOUNT_X = 2'd1;
    localparam logic [1:0] REG_MOUNT_Y = 2'd2;
    localparam logic [1:0] REG_MOUNT_Z = 2'd3;
    localparam int QM_TERMS  = 16;
    localparam int NRM_TERMS = 4;
    localparam int ROT_TERMS = 2;
    localparam int ONE_TERM  = 1;
    localparam int SQ_STEPS  = 20;
    localparam int DIV_STEPS = 34;

    typedef enum logic [3:0] {
        S_IDLE, S_QREL, S_QMNT, S_NORM, S_SQRT, S_DIV, S_CORD,
        S_PX1, S_PX2, S_PY1, S_PY2, S_HD1, S_HD2, S_DONE
    } state_t;

    state_t state_reg;
    logic [5:0] cnt_reg;
    logic [1:0] div_k_reg;

    logic m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    logic signed [15:0] mount_reg [4];
    logic               ref_set_reg;
    logic signed [15:0] ref_q_reg [4];
    logic signed [15:0] vel_x_reg, vel_y_reg;
    logic [31:0]        heading_reg;
    logic [POS_WIDTH-1:0] posx_reg, posy_reg;

    // per-item working registers
    logic signed [15:0] q_reg [4];
    logic [15:0]        seq_reg;
    logic signed [15:0] ang_reg;
    logic [19:0]        el_reg;
    logic signed [15:0] rel_reg [4];
    logic signed [17:0] m_reg [4];
    logic [39:0]        n2_reg;
    logic signed [MA_W-1:0] tmp_reg;
    logic [39:0]        sq_v_reg, sq_r_reg, sq_bit_reg;
    logic [19:0]        n_reg;
    logic [19:0]        rem_reg;
    logic [33:0]        dq_reg;
    logic               dneg_reg;
    logic signed [15:0] h_reg [4];
    logic signed [CX_W-1:0] cx_reg, cy_reg;
    logic signed [CZ_W-1:0] cz_reg;
    logic               flip_reg;
    logic signed [16:0] cos_reg, sin_reg;

    mac_ctl_t               mac_ctl;
    logic signed [MA_W-1:0] mac_a;
    logic signed [MB_W-1:0] mac_b;
    mac_fin_t               mac_fin;
    logic signed [ACC_W-1:0] mac_acc;

    logic [1:0] g, t, bi;
    logic       cfg_wr;
    logic       s_acc;
    logic signed [23:0] el_s;

    // sqrt step
    logic [39:0] sq_sum;
    // divider step
    logic [20:0] dv_t;
    logic [17:0] m_mag;
    // rotation step
    logic [4:0]  ci;
    logic signed [CZ_W-1:0] atan_s;
    logic signed [CX_W-1:0] cx_sh, cy_sh;
    logic signed [CX_W-1:0] c_rnd, s_rnd;
    logic [31:0] hq, ang_q, ang_f;
    logic        flip_c;
    logic signed [ACC_W-1:0] acc_sh15, acc_sh24;
    logic signed [63:0] posx_ext, posy_ext;

    imuoi_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .a     (mac_a),
        .b     (mac_b),
        .fin   (mac_fin),
        .acc   (mac_acc)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;

    // register read
    always_comb
    begin
        case (paddr[3:2])
            REG_MOUNT_W: prdata = {16'd0, mount_reg[0]};
            REG_MOUNT_X: prdata = {16'd0, mount_reg[1]};
            REG_MOUNT_Y: prdata = {16'd0, mount_reg[2]};
            REG_MOUNT_Z: prdata = {16'd0, mount_reg[3]};
            default:     prdata = '0;
        endcase
    end

    // operand selection for the shared multiplier
    always_comb
    begin
        g       = cnt_reg[3:2];
        t       = cnt_reg[1:0];
        bi      = t ^ g;
        el_s    = signed'({4'd0, el_reg});
        mac_ctl = '0;
        mac_a   = '0;
        mac_b   = '0;
        case (state_reg)
            S_QREL:
            begin
                if (cnt_reg < 6'(QM_TERMS))
                begin
                    mac_ctl.en   = 1'b1;
                    mac_ctl.clr  = (t == 2'd0);
                    mac_ctl.last = (t == 2'd3);
                    mac_ctl.dst  = DST_REL;
                    mac_ctl.idx  = g;
                    // conjugate of the reference folds into the sign
                    mac_ctl.neg  = ham_neg(g, t) ^ (t != 2'd0);
                    mac_a = MA_W'(ref_q_reg[t]);
                    mac_b = MB_W'(q_reg[bi]);
                end
            end
            S_QMNT:
            begin
                if (cnt_reg < 6'(QM_TERMS))
                begin
                    mac_ctl.en   = 1'b1;
                    mac_ctl.clr  = (t == 2'd0);
                    mac_ctl.last = (t == 2'd3);
                    mac_ctl.dst  = DST_MNT;
                    mac_ctl.idx  = g;
                    mac_ctl.neg  = ham_neg(g, t);
                    mac_a = MA_W'(mount_reg[t]);
                    mac_b = MB_W'(rel_reg[bi]);
                end
            end
            S_NORM:
            begin
                if (cnt_reg < 6'(NRM_TERMS))
                begin
                    mac_ctl.en   = 1'b1;
                    mac_ctl.clr  = (t == 2'd0);
                    mac_ctl.last = (t == 2'd3);
                    mac_ctl.dst  = DST_N2;
                    mac_a = MA_W'(m_reg[t]);
                    mac_b = MB_W'(m_reg[t]);
                end
            end
            S_PX1, S_PY1:
            begin
                if (cnt_reg < 6'(ROT_TERMS))
                begin
                    mac_ctl.en   = 1'b1;
                    mac_ctl.clr  = (t == 2'd0);
                    mac_ctl.last = (t == 2'd1);
                    mac_ctl.dst  = DST_TMP;
                    mac_ctl.neg  = (state_reg == S_PX1) && (t == 2'd1);
                    mac_a = (t == 2'd0) ? MA_W'(vel_x_reg) : MA_W'(vel_y_reg);
                    if (state_reg == S_PX1)
                        mac_b = (t == 2'd0) ? MB_W'(cos_reg) : MB_W'(sin_reg);
                    else
                        mac_b = (t == 2'd0) ? MB_W'(sin_reg) : MB_W'(cos_reg);
                end
            end
            S_PX2, S_PY2:
            begin
                if (cnt_reg < 6'(ONE_TERM))
                begin
                    mac_ctl.en   = 1'b1;
                    mac_ctl.clr  = 1'b1;
                    mac_ctl.last = 1'b1;
                    mac_ctl.dst  = (state_reg == S_PX2) ? DST_POSX : DST_POSY;
                    mac_a = tmp_reg;
                    mac_b = el_s;
                end
            end
            S_HD1:
            begin
                if (cnt_reg < 6'(ONE_TERM))
                begin
                    mac_ctl.en   = 1'b1;
                    mac_ctl.clr  = 1'b1;
                    mac_ctl.last = 1'b1;
                    mac_ctl.dst  = DST_TMP;
                    mac_a = MA_W'(ang_reg);
                    mac_b = el_s;
                end
            end
            S_HD2:
            begin
                if (cnt_reg < 6'(ONE_TERM))
                begin
                    mac_ctl.en   = 1'b1;
                    mac_ctl.clr  = 1'b1;
                    mac_ctl.last = 1'b1;
                    mac_ctl.dst  = DST_HEAD;
                    mac_a = tmp_reg;
                    mac_b = HEAD_K;
                end
            end
            default:
            begin
                mac_ctl = '0;
            end
        endcase
    end

    // step helpers
    always_comb
    begin
        sq_sum   = sq_r_reg + sq_bit_reg;
        dv_t     = {rem_reg, dq_reg[33]};
        m_mag    = m_reg[div_k_reg][17] ? 18'(-m_reg[div_k_reg]) : 18'(m_reg[div_k_reg]);
        ci       = 5'(cnt_reg - 6'd1);
        atan_s   = signed'({3'd0, atan_angle(ci)});
        cx_sh    = cx_reg >>> ci;
        cy_sh    = cy_reg >>> ci;
        c_rnd    = (cx_reg + 34'sd16384) >>> 15;
        s_rnd    = (cy_reg + 34'sd16384) >>> 15;
        hq       = heading_reg + (32'd1 << (31 - TRIG_BITS));
        ang_q    = {hq[31 -: TRIG_BITS], {(32-TRIG_BITS){1'b0}}};
        flip_c   = ang_q[31] ^ ang_q[30];
        ang_f    = {ang_q[31] ^ flip_c, ang_q[30:0]};
        acc_sh15 = mac_acc >>> 15;
        acc_sh24 = mac_acc >>> 24;
        posx_ext = 64'(signed'(posx_reg));
        posy_ext = 64'(signed'(posy_reg));
    end

    // sequencer, config and kept state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            div_k_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            mount_reg[0] <= 16'sd23170;
            mount_reg[1] <= 16'sd0;
            mount_reg[2] <= 16'sd0;
            mount_reg[3] <= -16'sd23170;
            ref_set_reg  <= 1'b0;
            for (int k = 0; k < 4; k++)
                ref_q_reg[k] <= '0;
            vel_x_reg    <= '0;
            vel_y_reg    <= '0;
            heading_reg  <= '0;
            posx_reg     <= '0;
            posy_reg     <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (paddr[3:2])
                    REG_MOUNT_W: mount_reg[0] <= pwdata[15:0];
                    REG_MOUNT_X: mount_reg[1] <= pwdata[15:0];
                    REG_MOUNT_Y: mount_reg[2] <= pwdata[15:0];
                    REG_MOUNT_Z: mount_reg[3] <= pwdata[15:0];
                    default:     mount_reg[0] <= mount_reg[0];
                endcase
            end

            // a result leaves; the output step refills the register itself
            if (m_tvalid_reg && m_tready && state_reg != S_DONE)
                m_tvalid_reg <= 1'b0;

            // finished sums that update kept state
            if (mac_fin.valid)
            begin
                case (mac_fin.dst)
                    DST_POSX: posx_reg <= posx_reg + POS_WIDTH'(acc_sh15);
                    DST_POSY: posy_reg <= posy_reg + POS_WIDTH'(acc_sh15);
                    DST_HEAD: heading_reg <= heading_reg + 32'(acc_sh24);
                    default:  heading_reg <= heading_reg;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    cnt_reg <= '0;
                    if (s_acc)
                    begin
                        if (s_tuser == CMD_VEL)
                        begin
                            vel_x_reg <= s_tdata[15:0];
                            vel_y_reg <= s_tdata[31:16];
                        end
                        else
                        begin
                            if (!ref_set_reg)
                            begin
                                ref_set_reg  <= 1'b1;
                                ref_q_reg[0] <= s_tdata[63:48];
                                ref_q_reg[1] <= s_tdata[79:64];
                                ref_q_reg[2] <= s_tdata[95:80];
                                ref_q_reg[3] <= s_tdata[111:96];
                            end
                            state_reg <= S_QREL;
                        end
                    end
                end
                S_QREL:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(QM_TERMS + 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_QMNT;
                    end
                end
                S_QMNT:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(QM_TERMS + 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_NORM;
                    end
                end
                S_NORM:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(NRM_TERMS + 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(SQ_STEPS + 1))
                    begin
                        cnt_reg   <= '0;
                        div_k_reg <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if ((cnt_reg == '0 && n_reg == '0) || cnt_reg == 6'(DIV_STEPS + 1))
                    begin
                        cnt_reg   <= '0;
                        div_k_reg <= div_k_reg + 2'd1;
                        if (div_k_reg == 2'd3)
                            state_reg <= S_CORD;
                    end
                end
                S_CORD:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(CORDIC_STEPS + 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_PX1;
                    end
                end
                S_PX1, S_PY1:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(ROT_TERMS + 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= (state_reg == S_PX1) ? S_PX2 : S_PY2;
                    end
                end
                S_PX2, S_PY2, S_HD1, S_HD2:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(ONE_TERM + 1))
                    begin
                        cnt_reg <= '0;
                        case (state_reg)
                            S_PX2:   state_reg <= S_PY1;
                            S_PY2:   state_reg <= S_HD1;
                            S_HD1:   state_reg <= S_HD2;
                            default: state_reg <= S_DONE;
                        endcase
                    end
                end
                S_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {h_reg[3], h_reg[2], h_reg[1], h_reg[0],
                                         rel_reg[3], rel_reg[2], rel_reg[1], rel_reg[0],
                                         posy_ext[47:0], posx_ext[47:0], seq_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // working datapath
    always_ff @(posedge clk)
    begin
        if (s_acc && s_tuser != CMD_VEL)
        begin
            seq_reg  <= s_tdata[47:32];
            q_reg[0] <= s_tdata[63:48];
            q_reg[1] <= s_tdata[79:64];
            q_reg[2] <= s_tdata[95:80];
            q_reg[3] <= s_tdata[111:96];
            ang_reg  <= s_tdata[127:112];
            el_reg   <= s_tdata[147:128];
        end

        // finished sums of the quaternion products, the norm and the temporary term
        if (mac_fin.valid)
        begin
            case (mac_fin.dst)
                DST_REL: rel_reg[mac_fin.idx] <= sat16(acc_sh15);
                DST_MNT: m_reg[mac_fin.idx]   <= 18'(acc_sh15);
                DST_N2:  n2_reg               <= mac_acc[39:0];
                DST_TMP: tmp_reg              <= mac_acc[MA_W-1:0];
                default: tmp_reg              <= tmp_reg;
            endcase
        end

        // integer square root, two bits of the radicand a step
        if (state_reg == S_SQRT)
        begin
            if (cnt_reg == '0)
            begin
                sq_v_reg   <= n2_reg;
                sq_r_reg   <= '0;
                sq_bit_reg <= 40'd1 << 38;
            end
            else if (cnt_reg <= 6'(SQ_STEPS))
            begin
                if (sq_v_reg >= sq_sum)
                begin
                    sq_v_reg <= sq_v_reg - sq_sum;
                    sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_r_reg <= sq_r_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            else
            begin
                n_reg <= sq_r_reg[19:0];
            end
        end

        // restoring divider, one quotient bit a step
        if (state_reg == S_DIV)
        begin
            if (cnt_reg == '0)
            begin
                if (n_reg == '0)
                begin
                    // zero norm gives the identity heading
                    h_reg[div_k_reg] <= (div_k_reg == 2'd0) ? 16'sh7fff : 16'sh0000;
                end
                dq_reg   <= {1'b0, m_mag, 15'd0} + 34'(n_reg >> 1);
                rem_reg  <= '0;
                dneg_reg <= m_reg[div_k_reg][17];
            end
            else if (cnt_reg <= 6'(DIV_STEPS))
            begin
                if (dv_t >= {1'b0, n_reg})
                begin
                    rem_reg <= 20'(dv_t - {1'b0, n_reg});
                    dq_reg  <= {dq_reg[32:0], 1'b1};
                end
                else
                begin
                    rem_reg <= dv_t[19:0];
                    dq_reg  <= {dq_reg[32:0], 1'b0};
                end
            end
            else
            begin
                if (dneg_reg)
                    h_reg[div_k_reg] <= (dq_reg > 34'd32768) ? 16'sh8000 : 16'(-dq_reg);
                else
                    h_reg[div_k_reg] <= (dq_reg > 34'd32767) ? 16'sh7fff : 16'(dq_reg);
            end
        end

        // sine and cosine of the quantized heading
        if (state_reg == S_CORD)
        begin
            if (cnt_reg == '0)
            begin
                cx_reg   <= CORDIC_X0;
                cy_reg   <= '0;
                cz_reg   <= CZ_W'(signed'(ang_f));
                flip_reg <= flip_c;
            end
            else if (cnt_reg <= 6'(CORDIC_STEPS))
            begin
                if (cz_reg >= 0)
                begin
                    cx_reg <= cx_reg - cy_sh;
                    cy_reg <= cy_reg + cx_sh;
                    cz_reg <= cz_reg - atan_s;
                end
                else
                begin
                    cx_reg <= cx_reg + cy_sh;
                    cy_reg <= cy_reg - cx_sh;
                    cz_reg <= cz_reg + atan_s;
                end
            end
            else
            begin
                cos_reg <= flip_reg ? 17'(-c_rnd) : 17'(c_rnd);
                sin_reg <= flip_reg ? 17'(-s_rnd) : 17'(s_rnd);
            end
        end
    end

    // the zero reference never unlatches
    a_ref_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ref_set_reg |=> ref_set_reg)
        else $error("zero reference dropped");

    // a finished sum follows the last term of its group through the control and finish registers
    a_fin_timing: assert property (@(posedge clk) disable iff (!rst_n)
        mac_fin.valid |-> $past(mac_ctl.en && mac_ctl.last, 2))
        else $error("accumulator finish without a closing term");

    // a result appears only out of the final sequencer step
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the output step");

    // no item is taken while an imu item is being worked
    a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_tready)
        else $error("input taken while busy");

endmodule
